>>> rtl/core/adc_serial_register_interface_defines.svh
// ----------------------------------------------------------------------------
// ADC serial register interface assertion macros
// Shared property forms for the concurrent checks of the block.
// ----------------------------------------------------------------------------
`ifndef ADC_SERIAL_REGISTER_INTERFACE_DEFINES_SVH
`define ADC_SERIAL_REGISTER_INTERFACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASRI_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASRI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/asri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC serial register interface package
// Field widths, register select codes, transfer phases and helpers.
// ----------------------------------------------------------------------------
package asri_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned SAMPLE_W = 24;

   localparam logic [1:0] WIDE_BYTES   = 2'd3;
   localparam logic [1:0] NARROW_BYTES = 2'd1;

   typedef enum logic [1:0] {
      PH_CMD   = 2'd0,
      PH_WRITE = 2'd1,
      PH_READ  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      REG_COMM      = 3'd0,
      REG_SETUP     = 3'd1,
      REG_FILTER_HI = 3'd2,
      REG_DATA      = 3'd3,
      REG_TEST      = 3'd4,
      REG_FILTER_LO = 3'd5,
      REG_ZERO_CAL  = 3'd6,
      REG_FULL_CAL  = 3'd7
   } reg_sel_type;

   localparam int unsigned READ_BIT = 3;

   function automatic logic [1:0] reg_bytes(input reg_sel_type sel);
      logic [1:0] n;
      unique case (sel)
         REG_DATA, REG_ZERO_CAL, REG_FULL_CAL: n = WIDE_BYTES;
         default:                              n = NARROW_BYTES;
      endcase
      return n;
   endfunction

endpackage

>>> rtl/core/asri_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC serial register interface channels
// Valid/ready channels for host words and sample events, and for responses.
// ----------------------------------------------------------------------------
interface asri_req_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [asri_pkg::BYTE_W-1:0]      byte_in;
   logic [asri_pkg::SAMPLE_W-1:0]    sample_value;

   modport source (output valid, kind, byte_in, sample_value, input ready);
   modport sink   (input valid, kind, byte_in, sample_value, output ready);
endinterface

interface asri_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [asri_pkg::BYTE_W-1:0] byte_out;
   logic                        last_byte;
   logic                        not_ready;

   modport source (output valid, byte_out, last_byte, not_ready, input ready);
   modport sink   (input valid, byte_out, last_byte, not_ready, output ready);
endinterface

>>> rtl/core/adc_serial_register_interface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC serial register interface
// Device side of a sigma-delta converter's byte-wide register port.
// ----------------------------------------------------------------------------
// The request channel carries one word per item: either a host byte from the
// serial line or a new conversion sample. Every host byte produces exactly one
// response word on the response channel, carrying the byte shifted back to the
// host, a flag marking the end of a register read and the not-ready level.
// Samples load the data register, clear not-ready and setup bits 7:6 and get
// no response. Each word is handled in the cycle it is accepted, and its
// response is held in the output register from the next cycle on. One word
// is taken per cycle while the receiver keeps up. The request channel is
// ready whenever the output register is empty or is being emptied in the
// same cycle; when the receiver stalls with a response pending, the request
// channel stalls with it. Reset returns the port to waiting for a command
// byte, zeroes all but the response byte and its flags, and sets not-ready.
// ----------------------------------------------------------------------------
module adc_serial_register_interface (
   input logic           clock,
   input logic           reset,
   asri_req_if.sink      req_chan,
   asri_rsp_if.source    rsp_chan
);
   import asri_pkg::*;
   `include "adc_serial_register_interface_defines.svh"

   phase_type             phase_ff, phase_in;
   reg_sel_type           sel_ff, sel_in;
   logic [1:0]            left_ff, left_in;
   logic [1:0]            chan_ff, chan_in;
   logic [SAMPLE_W-1:0]   shift_ff, shift_in;
   logic [BYTE_W-1:0]     setup_ff, setup_in;
   logic [BYTE_W-1:0]     filter_hi_ff, filter_hi_in;
   logic [BYTE_W-1:0]     test_ff, test_in;
   logic [BYTE_W-1:0]     filter_lo_ff, filter_lo_in;
   logic [SAMPLE_W-1:0]   data_ff, data_in;
   logic [SAMPLE_W-1:0]   zero_cal_ff, zero_cal_in;
   logic [SAMPLE_W-1:0]   full_cal_ff, full_cal_in;
   logic                  nrdy_ff, nrdy_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_nrdy_ff, rsp_nrdy_in;

   logic                  accept;
   logic [BYTE_W-1:0]     obyte;
   logic                  last;

   assign req_chan.ready     = !rsp_valid_ff || rsp_chan.ready;
   assign accept             = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.byte_out  = rsp_byte_ff;
   assign rsp_chan.last_byte = rsp_last_ff;
   assign rsp_chan.not_ready = rsp_nrdy_ff;

   always_comb begin
      logic [SAMPLE_W-1:0] wbuf;
      logic [SAMPLE_W-1:0] rval;
      logic [1:0]          cmd_chan;
      logic [1:0]          left_dec;
      reg_sel_type         cmd_sel;

      phase_in     = phase_ff;
      sel_in       = sel_ff;
      left_in      = left_ff;
      chan_in      = chan_ff;
      shift_in     = shift_ff;
      setup_in     = setup_ff;
      filter_hi_in = filter_hi_ff;
      test_in      = test_ff;
      filter_lo_in = filter_lo_ff;
      data_in      = data_ff;
      zero_cal_in  = zero_cal_ff;
      full_cal_in  = full_cal_ff;
      nrdy_in      = nrdy_ff;

      wbuf     = {shift_ff[SAMPLE_W-BYTE_W-1:0], req_chan.byte_in};
      cmd_sel  = reg_sel_type'(req_chan.byte_in[6:4]);
      cmd_chan = req_chan.byte_in[1:0];
      left_dec = left_ff - 2'd1;
      rval     = '0;

      unique case (cmd_sel)
         REG_COMM:      rval = {{(SAMPLE_W-BYTE_W){1'b0}}, nrdy_ff, 3'b000, 1'b1, 1'b0,
                                cmd_chan};
         REG_SETUP:     rval = {{(SAMPLE_W-BYTE_W){1'b0}}, setup_ff};
         REG_FILTER_HI: rval = {{(SAMPLE_W-BYTE_W){1'b0}}, filter_hi_ff};
         REG_DATA:      rval = data_ff;
         REG_TEST:      rval = {{(SAMPLE_W-BYTE_W){1'b0}}, test_ff};
         REG_FILTER_LO: rval = {{(SAMPLE_W-BYTE_W){1'b0}}, filter_lo_ff};
         REG_ZERO_CAL:  rval = zero_cal_ff;
         REG_FULL_CAL:  rval = full_cal_ff;
         default:       rval = '0;
      endcase

      if (accept && req_chan.kind) begin
         data_in  = req_chan.sample_value;
         nrdy_in  = 1'b0;
         setup_in = {2'b00, setup_ff[5:0]};
      end else if (accept) begin
         if (phase_ff == PH_READ && left_ff != 2'd0) begin
            left_in = left_dec;
            if (left_dec == 2'd0) begin
               phase_in = PH_CMD;
               if (sel_ff == REG_DATA) begin
                  nrdy_in = 1'b1;
               end
            end
         end else if (phase_ff == PH_WRITE && left_ff != 2'd0) begin
            shift_in = wbuf;
            left_in  = left_dec;
            if (left_dec == 2'd0) begin
               phase_in = PH_CMD;
               unique case (sel_ff)
                  REG_SETUP: begin
                     setup_in = wbuf[BYTE_W-1:0];
                     if (wbuf[7:6] != 2'b00) begin
                        nrdy_in = 1'b1;
                     end
                  end
                  REG_FILTER_HI: filter_hi_in = wbuf[BYTE_W-1:0];
                  REG_TEST:      test_in      = wbuf[BYTE_W-1:0];
                  REG_FILTER_LO: filter_lo_in = wbuf[BYTE_W-1:0];
                  REG_ZERO_CAL:  zero_cal_in  = wbuf;
                  REG_FULL_CAL:  full_cal_in  = wbuf;
                  default:       ;
               endcase
            end
         end else begin
            sel_in  = cmd_sel;
            chan_in = cmd_chan;
            if (req_chan.byte_in[READ_BIT]) begin
               shift_in = rval;
               left_in  = reg_bytes(cmd_sel);
               phase_in = PH_READ;
            end else if (cmd_sel == REG_COMM) begin
               left_in  = 2'd0;
               phase_in = PH_CMD;
            end else begin
               shift_in = '0;
               left_in  = reg_bytes(cmd_sel);
               phase_in = PH_WRITE;
            end
         end
      end
   end

   always_comb begin
      obyte = '0;
      last  = 1'b0;
      if (phase_ff == PH_READ && left_ff != 2'd0) begin
         case (left_ff)
            2'd1:    obyte = shift_ff[7:0];
            2'd2:    obyte = shift_ff[15:8];
            default: obyte = shift_ff[23:16];
         endcase
         last = (left_ff == 2'd1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_nrdy_in  = rsp_nrdy_ff;
      if (accept && !req_chan.kind) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = obyte;
         rsp_last_in  = last;
         rsp_nrdy_in  = nrdy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         sel_ff       <= REG_COMM;
         left_ff      <= 2'd0;
         chan_ff      <= 2'd0;
         shift_ff     <= '0;
         setup_ff     <= '0;
         filter_hi_ff <= '0;
         test_ff      <= '0;
         filter_lo_ff <= '0;
         data_ff      <= '0;
         zero_cal_ff  <= '0;
         full_cal_ff  <= '0;
         nrdy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sel_ff       <= sel_in;
         left_ff      <= left_in;
         chan_ff      <= chan_in;
         shift_ff     <= shift_in;
         setup_ff     <= setup_in;
         filter_hi_ff <= filter_hi_in;
         test_ff      <= test_in;
         filter_lo_ff <= filter_lo_in;
         data_ff      <= data_in;
         zero_cal_ff  <= zero_cal_in;
         full_cal_ff  <= full_cal_in;
         nrdy_ff      <= nrdy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_nrdy_ff <= rsp_nrdy_in;
   end

   `ASRI_ASSERT_SAME(a_cmd_no_bytes, clock, reset, phase_ff == PH_CMD, left_ff == 2'd0,
      "Bytes remain while waiting for a command word.")
   `ASRI_ASSERT_SAME(a_xfer_has_bytes, clock, reset, phase_ff != PH_CMD, left_ff != 2'd0,
      "A transfer is open with no bytes left.")
   `ASRI_ASSERT_NEXT(a_sample_clears, clock, reset, accept && req_chan.kind, !nrdy_ff,
      "A sample did not clear the not-ready flag.")
   `ASRI_ASSERT_NEXT(a_host_word_rsp, clock, reset, accept && !req_chan.kind,
      rsp_valid_ff && rsp_nrdy_ff == nrdy_ff,
      "A host word did not produce a matching response word.")

endmodule

>>> sim/asri_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC serial register interface checker
// Watches both channels, tracks the register port and compares every reply.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the port state and register file. Each
// accepted request word updates that copy, and each host byte queues the reply
// it must produce. Each accepted response word is compared with the oldest
// queued reply.
// ----------------------------------------------------------------------------
module asri_port_checker (
   input  logic  clock,
   input  logic  reset,
   asri_req_if   req_mon,
   asri_rsp_if   rsp_mon,
   output int    fail_total,
   output int    replies_owed
);
   import asri_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       nrdy;
   } reply_type;

   phase_type   port_phase;
   reg_sel_type port_sel;
   logic [1:0]  bytes_to_go;
   logic [1:0]  port_chan;
   logic [23:0] shift_q;
   logic [23:0] reg_file [8];
   logic        nrdy_q;

   reply_type   pending_replies [$];
   int          fail_tally = 0;
   int          owed_count = 0;

   assign fail_total   = fail_tally;
   assign replies_owed = owed_count;

   task automatic clear_port();
      port_phase  = PH_CMD;
      port_sel    = REG_COMM;
      bytes_to_go = 2'd0;
      port_chan   = 2'd0;
      shift_q     = 24'd0;
      nrdy_q      = 1'b1;
      for (int i = 0; i < 8; i++) begin
         reg_file[i] = 24'd0;
      end
   endtask

   task automatic store_register();
      if (port_sel == REG_ZERO_CAL || port_sel == REG_FULL_CAL) begin
         reg_file[port_sel] = shift_q;
      end else if (port_sel != REG_COMM && port_sel != REG_DATA) begin
         reg_file[port_sel] = {16'd0, shift_q[7:0]};
         if (port_sel == REG_SETUP && shift_q[7:6] != 2'b00) begin
            nrdy_q = 1'b1;
         end
      end
   endtask

   task automatic predict_port_word(input logic is_sample, input logic [7:0] host_byte,
                                    input logic [23:0] sample, output logic replies,
                                    output reply_type reply);
      reg_sel_type sel;
      logic [1:0]  span;
      logic [23:0] shifted;
      reply   = '0;
      replies = 1'b0;
      if (is_sample) begin
         reg_file[REG_DATA]       = sample;
         reg_file[REG_SETUP][7:6] = 2'b00;
         nrdy_q                   = 1'b0;
      end else begin
         if (port_phase == PH_READ && bytes_to_go != 2'd0) begin
            shifted     = shift_q >> (8 * (int'(bytes_to_go) - 1));
            reply.data  = shifted[7:0];
            bytes_to_go = bytes_to_go - 2'd1;
            if (bytes_to_go == 2'd0) begin
               reply.last = 1'b1;
               port_phase = PH_CMD;
               if (port_sel == REG_DATA) begin
                  nrdy_q = 1'b1;
               end
            end
         end else if (port_phase == PH_WRITE && bytes_to_go != 2'd0) begin
            shift_q     = {shift_q[15:0], host_byte};
            bytes_to_go = bytes_to_go - 2'd1;
            if (bytes_to_go == 2'd0) begin
               store_register();
               port_phase = PH_CMD;
            end
         end else begin
            sel = reg_sel_type'(host_byte[6:4]);
            span = (sel == REG_DATA || sel == REG_ZERO_CAL || sel == REG_FULL_CAL) ?
                   2'd3 : 2'd1;
            port_sel  = sel;
            port_chan = host_byte[1:0];
            if (host_byte[READ_BIT]) begin
               if (sel == REG_COMM) begin
                  shift_q = {16'd0, nrdy_q, 3'b000, 1'b1, 1'b0, port_chan};
               end else begin
                  shift_q = reg_file[sel];
               end
               bytes_to_go = span;
               port_phase  = PH_READ;
            end else if (sel == REG_COMM) begin
               bytes_to_go = 2'd0;
               port_phase  = PH_CMD;
            end else begin
               shift_q     = 24'd0;
               bytes_to_go = span;
               port_phase  = PH_WRITE;
            end
         end
         reply.nrdy = nrdy_q;
         replies    = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      reply_type seen;
      reply_type want;
      reply_type made;
      logic      has_reply;
      if (reset) begin
         clear_port();
         pending_replies.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.byte_out, rsp_mon.last_byte, rsp_mon.not_ready};
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected word, expected none, got byte %02h last %b nrdy %b",
                        $time, seen.data, seen.last, seen.nrdy);
               fail_tally++;
            end else begin
               want = pending_replies.pop_front();
               if (seen.data !== want.data) begin
                  $display("%0t: byte_out expected %02h, got %02h", $time, want.data,
                           seen.data);
                  fail_tally++;
               end
               if (seen.last !== want.last) begin
                  $display("%0t: last_byte expected %b, got %b", $time, want.last, seen.last);
                  fail_tally++;
               end
               if (seen.nrdy !== want.nrdy) begin
                  $display("%0t: not_ready expected %b, got %b", $time, want.nrdy, seen.nrdy);
                  fail_tally++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_port_word(req_mon.kind, req_mon.byte_in, req_mon.sample_value,
                              has_reply, made);
            if (has_reply) begin
               pending_replies.push_back(made);
            end
         end
      end
      owed_count = pending_replies.size();
   end

endmodule

>>> sim/tb_adc_serial_register_interface.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADC serial register interface testbench
// Drives host bytes and samples into the port and judges the replies.
// ----------------------------------------------------------------------------
// A directed opening covers command decoding, calibration, snapshot reads and
// ignored data writes. Random register transfers with interleaved samples and
// stray bytes follow, with idling bursts on both channels in alternate runs of
// 64 words, not near the end. The checker by the block reports every mismatch.
// ----------------------------------------------------------------------------
module tb_adc_serial_register_interface;
   import asri_pkg::*;

   localparam int TOTAL_WORDS = 750;
   localparam int QUIET_FROM  = 640;
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset;
   logic req_taken;
   logic quiet;
   int   sent;
   int   cycles;
   int   stall_left;
   int   fails;
   int   owed;

   asri_req_if req_chan ();
   asri_rsp_if rsp_chan ();

   adc_serial_register_interface dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   asri_port_checker port_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .fail_total   (fails),
      .replies_owed (owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
      cycles    <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (!reset && !quiet && !sent[6] && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 3);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic push_word(input logic is_sample, input logic [7:0] host_byte,
                            input logic [23:0] sample);
      int gap;
      if (!quiet && !sent[6] && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.kind         <= is_sample;
      req_chan.byte_in      <= host_byte;
      req_chan.sample_value <= sample;
      do @(negedge clock); while (!req_taken);
      sent++;
   endtask

   task automatic host(input logic [7:0] host_byte);
      push_word(1'b0, host_byte, 24'($urandom_range(0, 24'hFFFFFF)));
   endtask

   task automatic fresh_sample(input logic [23:0] sample);
      push_word(1'b1, 8'($urandom_range(0, 255)), sample);
   endtask

   task automatic run_transfer();
      logic [7:0]  cmd;
      reg_sel_type sel;
      int          span;
      cmd = 8'($urandom_range(0, 255));
      sel = reg_sel_type'(cmd[6:4]);
      span = (sel == REG_DATA || sel == REG_ZERO_CAL || sel == REG_FULL_CAL) ? 3 : 1;
      host(cmd);
      if (cmd[READ_BIT] || sel != REG_COMM) begin
         for (int i = 0; i < span; i++) begin
            if ($urandom_range(0, 5) == 0) begin
               fresh_sample(24'($urandom_range(0, 24'hFFFFFF)));
            end
            host(8'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      int pick;
      reset                 = 1'b1;
      quiet                 = 1'b0;
      sent                  = 0;
      cycles                = 0;
      stall_left            = 0;
      req_taken             = 1'b0;
      req_chan.valid        = 1'b0;
      req_chan.kind         = 1'b0;
      req_chan.byte_in      = 8'd0;
      req_chan.sample_value = 24'd0;
      rsp_chan.ready        = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Status read after reset, then a bare channel select and a setup read.
      host(8'h08);
      host(8'h00);
      host(8'h03);
      host(8'h1B);
      host(8'hFF);
      // Calibration request, finished by the next sample.
      host(8'h10);
      host(8'hC0);
      fresh_sample(24'hFFFFFF);
      // A data read keeps its snapshot when a sample lands mid-transfer.
      host(8'h38);
      fresh_sample(24'h000000);
      host(8'h00);
      host(8'hFF);
      host(8'h00);
      // Data register writes are swallowed.
      host(8'h30);
      host(8'hAA);
      host(8'h55);
      host(8'hAA);
      // Ignored command bits set on a calibration register write and read.
      host(8'hE4);
      host(8'hFF);
      host(8'hFF);
      host(8'hFF);
      host(8'h6B);
      host(8'h00);
      host(8'h00);
      host(8'h00);

      while (sent < TOTAL_WORDS) begin
         if (sent >= QUIET_FROM) begin
            quiet = 1'b1;
         end
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            run_transfer();
         end else if (pick == 8) begin
            fresh_sample(24'($urandom_range(0, 24'hFFFFFF)));
         end else begin
            host(8'($urandom_range(0, 255)));
         end
      end
      quiet = 1'b1;
      req_chan.valid <= 1'b0;

      while (owed != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (fails == 0 && owed == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
